/* hdl/ptts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared constants for the periodic task tick scheduler: field widths, mode,
// kind and status codes, and the default slot count.
// ----------------------------------------------------------------------------
package ptts_pkg;

  // default number of task slots
  localparam int unsigned TASK_SLOTS_DEF = 8;

  // beat field widths
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 2;

  // input modes
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CREATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd2;

  // create and delete status codes
  localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_IN_USE     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_HANDLER = 2'd2;

endpackage : ptts_pkg
`default_nettype wire

/* hdl/ptts_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptts_if
// Valid/ready channels of the scheduler: command beats in, result beats out.
// ----------------------------------------------------------------------------
interface ptts_in_if;
  import ptts_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [SLOT_W-1:0]   slot;
  logic [TIME_W-1:0]   period;
  logic [TIME_W-1:0]   first_delay;
  logic                handler_given;

  modport source (
    output valid, mode, slot, period, first_delay, handler_given,
    input  ready
  );

  modport sink (
    input  valid, mode, slot, period, first_delay, handler_given,
    output ready
  );
endinterface : ptts_in_if

interface ptts_out_if;
  import ptts_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SLOT_W-1:0]   fired_slot;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (
    output valid, kind, fired_slot, status, last,
    input  ready
  );

  modport sink (
    input  valid, kind, fired_slot, status, last,
    output ready
  );
endinterface : ptts_out_if
`default_nettype wire

/* hdl/periodic_task_tick_scheduler_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_unit
// Task slot table indexed by priority. Create and delete beats edit the
// table, tick beats walk it, decrementing or reloading each used countdown.
// ----------------------------------------------------------------------------
// Create, delete: the status is registered as pending, then moved to the
// output register in the final state once the output is free. Tick: every
// slot is read from the countdown memory and every used one goes through
// the shared decrementer. One command at a time; input is ready only in idle.
// Reset: clears all slot used bits and the sequencer; period and countdown
// memories are not cleared, no clearing pass is run.
module periodic_task_tick_scheduler_unit #(
  parameter int unsigned TASK_SLOTS = ptts_pkg::TASK_SLOTS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ptts_in_if.sink     item_i,
  ptts_out_if.source  result_o
);
  import ptts_pkg::*;

  localparam int unsigned IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TASK_SLOTS - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_CALC = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [TASK_SLOTS-1:0] used_q, used_d;

  // pending result, held until the next one or the end of the walk
  logic                pend_vld_q, pend_vld_d;
  logic [KIND_W-1:0]   pend_kind_q, pend_kind_d;
  logic [SLOT_W-1:0]   pend_slot_q, pend_slot_d;
  logic [STATUS_W-1:0] pend_status_q, pend_status_d;

  // output register
  logic                out_vld_q;
  logic [KIND_W-1:0]   out_kind_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [STATUS_W-1:0] out_status_q;
  logic                out_last_q;

  logic                out_free;
  logic                push;
  logic [KIND_W-1:0]   push_kind;
  logic [SLOT_W-1:0]   push_slot;
  logic [STATUS_W-1:0] push_status;
  logic                push_last;

  // slot memories
  logic [TIME_W-1:0] per_mem [TASK_SLOTS];
  logic [TIME_W-1:0] cd_mem  [TASK_SLOTS];
  logic [TIME_W-1:0] rd_per_q, rd_cd_q;

  logic              per_we, cd_we;
  logic [IDX_W-1:0]  wr_addr;
  logic [TIME_W-1:0] cd_wdata;

  logic              in_acc;
  logic [IDX_W-1:0]  slot_idx;
  logic              slot_ok;
  logic              fire;
  logic [TIME_W-1:0] dec_in, dec_out;

  assign in_acc   = item_i.valid && item_i.ready;
  assign slot_idx = IDX_W'(item_i.slot);
  assign slot_ok  = (int'(item_i.slot) < int'(TASK_SLOTS));
  assign out_free = !out_vld_q || result_o.ready;

  // shared decrementer: reload uses period - 1, else countdown - 1
  assign fire    = (rd_cd_q == '0);
  assign dec_in  = fire ? rd_per_q : rd_cd_q;
  assign dec_out = dec_in - TIME_W'(1);

  // sequencer
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    used_d        = used_q;
    pend_vld_d    = pend_vld_q;
    pend_kind_d   = pend_kind_q;
    pend_slot_d   = pend_slot_q;
    pend_status_d = pend_status_q;
    push          = 1'b0;
    push_kind     = pend_kind_q;
    push_slot     = pend_slot_q;
    push_status   = pend_status_q;
    push_last     = 1'b0;
    per_we        = 1'b0;
    cd_we         = 1'b0;
    wr_addr       = idx_q;
    cd_wdata      = dec_out;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (item_i.mode)
            MODE_TICK: begin
              idx_d      = '0;
              pend_vld_d = 1'b0;
              state_d    = ST_RD;
            end
            MODE_CREATE: begin
              pend_vld_d  = 1'b1;
              pend_kind_d = KIND_STATUS;
              pend_slot_d = '0;
              state_d     = ST_FIN;
              if (!item_i.handler_given) begin
                pend_status_d = STAT_NO_HANDLER;
              end else if (!slot_ok || used_q[slot_idx]) begin
                pend_status_d = STAT_IN_USE;
              end else begin
                pend_status_d    = STAT_OK;
                used_d[slot_idx] = 1'b1;
                per_we           = 1'b1;
                cd_we            = 1'b1;
                wr_addr          = slot_idx;
                cd_wdata         = item_i.first_delay;
              end
            end
            MODE_DELETE: begin
              if (slot_ok) begin
                used_d[slot_idx] = 1'b0;
              end
              pend_vld_d    = 1'b1;
              pend_kind_d   = KIND_STATUS;
              pend_slot_d   = '0;
              pend_status_d = STAT_OK;
              state_d       = ST_FIN;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_RD: begin
        // skip free slots, read countdown and period of used ones
        if (used_q[idx_q]) begin
          state_d = ST_CALC;
        end else if (idx_q == IDX_LAST) begin
          state_d = ST_FIN;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_CALC: begin
        if (!(fire && pend_vld_q && !out_free)) begin
          cd_we = 1'b1;
          if (fire) begin
            push          = pend_vld_q;
            pend_vld_d    = 1'b1;
            pend_kind_d   = KIND_FIRED;
            pend_slot_d   = SLOT_W'(idx_q);
            pend_status_d = STAT_OK;
          end
          if (idx_q == IDX_LAST) begin
            state_d = ST_FIN;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_RD;
          end
        end
      end
      ST_FIN: begin
        // final beat of the command carries last
        if (out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
          if (!pend_vld_q) begin
            push_kind   = KIND_NONE;
            push_slot   = '0;
            push_status = STAT_OK;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      used_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      used_q     <= used_d;
      pend_vld_q <= pend_vld_d;
      if (push) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_kind_q   <= pend_kind_d;
    pend_slot_q   <= pend_slot_d;
    pend_status_q <= pend_status_d;
    if (push) begin
      out_kind_q   <= push_kind;
      out_slot_q   <= push_slot;
      out_status_q <= push_status;
      out_last_q   <= push_last;
    end
  end

  // period and countdown memories, registered read
  always_ff @(posedge clk_i) begin
    if (per_we) begin
      per_mem[wr_addr] <= item_i.period;
    end
    if (cd_we) begin
      cd_mem[wr_addr] <= cd_wdata;
    end
    if (state_q == ST_RD) begin
      rd_per_q <= per_mem[idx_q];
      rd_cd_q  <= cd_mem[idx_q];
    end
  end

  assign item_i.ready        = (state_q == ST_IDLE);
  assign result_o.valid      = out_vld_q;
  assign result_o.kind       = out_kind_q;
  assign result_o.fired_slot = out_slot_q;
  assign result_o.status     = out_status_q;
  assign result_o.last       = out_last_q;

  // assertions
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_tick_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && item_i.mode == MODE_TICK) |=> (state_q == ST_RD && idx_q == '0))
    else $error("tick beat did not start the walk at slot zero");

  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_kind_q == KIND_NONE) |-> out_last_q)
    else $error("none-fired beat without last");

  a_calc_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |-> used_q[idx_q])
    else $error("countdown update on a free slot");

endmodule : periodic_task_tick_scheduler_unit
`default_nettype wire

/* verif/tb_periodic_task_tick_scheduler_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_periodic_task_tick_scheduler_unit
// Self-checking bench for the periodic task tick scheduler. Command beats
// (tick, create, delete, and the unused mode) go in with random gaps. A
// task table model in the bench predicts every result beat. A checker
// compares each result beat, field by field, against the oldest prediction
// while the result side stalls at random.
// ----------------------------------------------------------------------------
module tb_periodic_task_tick_scheduler_unit;
  import ptts_pkg::*;

  localparam int unsigned SLOTS        = TASK_SLOTS_DEF;
  localparam int unsigned RANDOM_ITEMS = 100;
  localparam int unsigned DRAIN_CYCLES = 2 * SLOTS + 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_REPORTS  = 10;

  // mode with no function, dropped by the block
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [SLOT_W-1:0]   slot;
    logic [TIME_W-1:0]   period;
    logic [TIME_W-1:0]   first_delay;
    logic                handler_given;
  } command_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   fired_slot;
    logic [STATUS_W-1:0] status;
    logic                last;
  } result_t;

  logic clk_i;
  logic rst_ni;

  ptts_in_if  item_if ();
  ptts_out_if result_if ();

  periodic_task_tick_scheduler_unit #(
    .TASK_SLOTS (SLOTS)
  ) u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if)
  );

  // task table as the bench sees it
  logic              slot_in_use [SLOTS];
  logic [TIME_W-1:0] slot_period [SLOTS];
  logic [TIME_W-1:0] slot_countdown [SLOTS];

  result_t     expected_results [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("periodic_task_tick_scheduler_unit: mismatch");
      $finish;
    end
  end

  // table model: apply one accepted command, queue the beats it causes
  function automatic void schedule_command(input command_t cmd);
    result_t     beat;
    int unsigned fired;
    logic [STATUS_W-1:0] st;
    fired = 0;
    case (cmd.mode)
      MODE_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_in_use[i]) begin
            if (slot_countdown[i] == '0) begin
              beat = '{kind: KIND_FIRED, fired_slot: SLOT_W'(i), status: STAT_OK,
                       last: 1'b0};
              expected_results.push_back(beat);
              fired++;
              slot_countdown[i] = slot_period[i] - 1'b1;
            end else begin
              slot_countdown[i] = slot_countdown[i] - 1'b1;
            end
          end
        end
        if (fired == 0) begin
          beat = '{kind: KIND_NONE, fired_slot: '0, status: STAT_OK, last: 1'b1};
          expected_results.push_back(beat);
        end else begin
          // flag the highest fired slot as the closing beat
          beat = expected_results.pop_back();
          beat.last = 1'b1;
          expected_results.push_back(beat);
        end
      end
      MODE_CREATE: begin
        if (!cmd.handler_given) begin
          st = STAT_NO_HANDLER;
        end else if (int'(cmd.slot) >= SLOTS) begin
          st = STAT_IN_USE;
        end else if (slot_in_use[cmd.slot]) begin
          st = STAT_IN_USE;
        end else begin
          slot_in_use[cmd.slot]    = 1'b1;
          slot_period[cmd.slot]    = cmd.period;
          slot_countdown[cmd.slot] = cmd.first_delay;
          st = STAT_OK;
        end
        beat = '{kind: KIND_STATUS, fired_slot: '0, status: st, last: 1'b1};
        expected_results.push_back(beat);
      end
      MODE_DELETE: begin
        if (int'(cmd.slot) < SLOTS) begin
          slot_in_use[cmd.slot] = 1'b0;
        end
        beat = '{kind: KIND_STATUS, fired_slot: '0, status: STAT_OK, last: 1'b1};
        expected_results.push_back(beat);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic command_t make_command(input logic [MODE_W-1:0] mode,
                                            input int unsigned slot,
                                            input int unsigned period,
                                            input int unsigned first_delay,
                                            input logic handler_given);
    command_t cmd;
    cmd.mode          = mode;
    cmd.slot          = SLOT_W'(slot);
    cmd.period        = TIME_W'(period);
    cmd.first_delay   = TIME_W'(first_delay);
    cmd.handler_given = handler_given;
    return cmd;
  endfunction

  // mostly back to back or short gaps, now and then a long one
  function automatic int unsigned random_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      return 0;
    end
    if (pick < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // drive one command beat after an idle gap, predict once accepted
  task automatic send_command(input command_t cmd, input int unsigned gap);
    if (gap > 0) begin
      @(negedge clk_i);
      item_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    item_if.valid         <= 1'b1;
    item_if.mode          <= cmd.mode;
    item_if.slot          <= cmd.slot;
    item_if.period        <= cmd.period;
    item_if.first_delay   <= cmd.first_delay;
    item_if.handler_given <= cmd.handler_given;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    schedule_command(cmd);
  endtask

  // result side backpressure: ready runs, short stalls, a few long stalls
  initial begin : result_ready_driver
    int unsigned pick;
    int unsigned hold;
    logic        level;
    result_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        level = 1'b1;
        hold  = $urandom_range(1, 30);
      end else if (pick < 88) begin
        level = 1'b0;
        hold  = $urandom_range(1, 3);
      end else begin
        level = 1'b0;
        hold  = $urandom_range(8, 40);
      end
      @(negedge clk_i);
      result_if.ready <= level;
      repeat (hold - 1) @(negedge clk_i);
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk_i) begin : result_checker
    result_t got;
    result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      got.kind       = result_if.kind;
      got.fired_slot = result_if.fired_slot;
      got.status     = result_if.status;
      got.last       = result_if.last;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("cycle %0d: unexpected result beat kind %0d slot %0d status %0d last %0d",
                   cycle_count, got.kind, got.fired_slot, got.status, got.last);
        end
      end else begin
        want = expected_results.pop_front();
        if (got.kind != want.kind || got.fired_slot != want.fired_slot ||
            got.status != want.status || got.last != want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("cycle %0d: expected kind %0d slot %0d status %0d last %0d",
                     cycle_count, want.kind, want.fired_slot, want.status, want.last);
            $display("cycle %0d: actual   kind %0d slot %0d status %0d last %0d",
                     cycle_count, got.kind, got.fired_slot, got.status, got.last);
          end
        end
      end
    end
  end

  // create and delete status codes, including check precedence
  task automatic test_create_status();
    send_command(make_command(MODE_CREATE, 0, 5, 5, 1'b0), random_gap());
    send_command(make_command(MODE_CREATE, 0, 1, 0, 1'b1), random_gap());
    // missing handler wins over slot in use
    send_command(make_command(MODE_CREATE, 0, 9, 9, 1'b0), random_gap());
    send_command(make_command(MODE_CREATE, 0, 7, 7, 1'b1), random_gap());
    // delete of a free slot still reports ok
    send_command(make_command(MODE_DELETE, 5, 0, 0, 1'b0), random_gap());
    send_command(make_command(MODE_CREATE, 7, 0, 0, 1'b1), random_gap());
    send_command(make_command(MODE_CREATE, 3, 3, 2, 1'b1), random_gap());
  endtask

  // firing order, reload with period zero and one, extremes, no-fire ticks
  task automatic test_tick_firing();
    repeat (3) send_command(make_command(MODE_TICK, 0, 0, 0, 1'b0), random_gap());
    // unused mode with every bit set gives no beat
    send_command(make_command(MODE_UNUSED, 7, 16'hffff, 16'hffff, 1'b1), random_gap());
    send_command(make_command(MODE_CREATE, 4, 16'hffff, 16'hffff, 1'b1), random_gap());
    send_command(make_command(MODE_TICK, 7, 16'hffff, 16'hffff, 1'b1), random_gap());
    send_command(make_command(MODE_DELETE, 0, 0, 0, 1'b0), random_gap());
    send_command(make_command(MODE_DELETE, 3, 0, 0, 1'b0), random_gap());
    send_command(make_command(MODE_DELETE, 7, 0, 0, 1'b0), random_gap());
    send_command(make_command(MODE_DELETE, 4, 0, 0, 1'b0), random_gap());
    send_command(make_command(MODE_TICK, 0, 0, 0, 1'b0), random_gap());
    send_command(make_command(MODE_CREATE, 6, 2, 1, 1'b1), random_gap());
    repeat (2) send_command(make_command(MODE_TICK, 0, 0, 0, 1'b0), random_gap());
    send_command(make_command(MODE_DELETE, 6, 0, 0, 1'b0), random_gap());
  endtask

  // mostly well formed traffic with short periods so tasks fire often,
  // plus full range noise and the unused mode
  task automatic test_random_traffic();
    int unsigned counted;
    int unsigned pick;
    command_t    cmd;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        cmd = make_command(MODE_TICK, $urandom_range(0, SLOTS - 1), $urandom(),
                           $urandom(), 1'($urandom()));
      end else if (pick < 75) begin
        cmd = make_command(MODE_CREATE, $urandom_range(0, SLOTS - 1),
                           $urandom_range(1, 6), $urandom_range(0, 5),
                           $urandom_range(0, 9) != 0);
      end else if (pick < 90) begin
        cmd = make_command(MODE_DELETE, $urandom_range(0, SLOTS - 1), $urandom(),
                           $urandom(), 1'($urandom()));
      end else if (pick < 96) begin
        cmd = make_command(MODE_CREATE, $urandom(), $urandom(), $urandom(),
                           1'($urandom()));
      end else begin
        cmd = make_command(MODE_UNUSED, $urandom(), $urandom(), $urandom(),
                           1'($urandom()));
      end
      send_command(cmd, random_gap());
      if (cmd.mode != MODE_UNUSED) begin
        counted++;
      end
    end
  endtask

  // reset, tests, drain, verdict
  initial begin : main_sequence
    rst_ni                = 1'b0;
    item_if.valid         = 1'b0;
    item_if.mode          = MODE_TICK;
    item_if.slot          = '0;
    item_if.period        = '0;
    item_if.first_delay   = '0;
    item_if.handler_given = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_in_use[i]    = 1'b0;
      slot_period[i]    = '0;
      slot_countdown[i] = '0;
    end
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_create_status();
    test_tick_firing();
    test_random_traffic();

    @(negedge clk_i);
    item_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("periodic_task_tick_scheduler_unit: match");
    end else begin
      $display("periodic_task_tick_scheduler_unit: mismatch");
    end
    $finish;
  end

endmodule : tb_periodic_task_tick_scheduler_unit
`default_nettype wire
